### hdl/cia_pkg.sv
`default_nettype none

package cia_pkg;

    // Function codes carried with each request
    typedef enum logic [1:0] {
        FUNC_MUL = 2'd0,
        FUNC_DIV = 2'd1,
        FUNC_MAX = 2'd2,
        FUNC_AVG = 2'd3
    } func_t;

    // Width of each result part
    localparam int RES_W = 33;

endpackage

`default_nettype wire

### hdl/complex_integer_alu.sv
`default_nettype none

// Complex integer ALU: multiply, divide, max by magnitude and average on
// Gaussian integers a = a_re + j*a_im and b = b_re + j*b_im.
//
// Request channel: req_valid/req_ready carries func and the four operand
// parts. Response channel: rsp_valid/rsp_ready carries res_re, res_im and
// div_by_zero. One response leaves for every request, in order.
//
// The request transfer loads the product register; then come the sum and
// magnitude register, one restoring divider stage per quotient bit, and the
// output register, which drives rsp_valid. Throughput is one item per cycle
// while the receiver does not stall; the unrolled divider sets the depth.
//
// Every stage carries its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled receiver only holds the stages that are full;
// bubbles ahead of the stall fill up and req_ready stays high until the whole
// pipe is full. Reset clears every valid bit; the data registers are not reset.
module complex_integer_alu #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic [1:0]                       func,
    input  wire logic signed [OPERAND_WIDTH-1:0]  a_re,
    input  wire logic signed [OPERAND_WIDTH-1:0]  a_im,
    input  wire logic signed [OPERAND_WIDTH-1:0]  b_re,
    input  wire logic signed [OPERAND_WIDTH-1:0]  b_im,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic signed [cia_pkg::RES_W-1:0]      res_re,
    output logic signed [cia_pkg::RES_W-1:0]      res_im,
    output logic                                  div_by_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int NW = 2 * W;      // products, magnitudes, quotients
    localparam int XW = 2 * W + 2;  // exact signed sums of products

    // Product stage contents
    typedef struct packed {
        cia_pkg::func_t          fn;
        logic signed [W-1:0]     ar;
        logic signed [W-1:0]     ai;
        logic signed [W-1:0]     br;
        logic signed [W-1:0]     bi;
        logic signed [NW-1:0]    arbr;
        logic signed [NW-1:0]    aibi;
        logic signed [NW-1:0]    aibr;
        logic signed [NW-1:0]    arbi;
        logic signed [NW-1:0]    sq_ar;
        logic signed [NW-1:0]    sq_ai;
        logic signed [NW-1:0]    sq_br;
        logic signed [NW-1:0]    sq_bi;
        logic signed [W:0]       avg_re;
        logic signed [W:0]       avg_im;
    } prod_t;

    // Divider stage contents; num shifts out numerator bits and takes in
    // quotient bits
    typedef struct packed {
        cia_pkg::func_t          fn;
        logic signed [XW-1:0]    val_re;
        logic signed [XW-1:0]    val_im;
        logic                    neg_re;
        logic                    neg_im;
        logic [NW-1:0]           d;
        logic [NW-1:0]           rem_re;
        logic [NW-1:0]           num_re;
        logic [NW-1:0]           rem_im;
        logic [NW-1:0]           num_im;
    } div_t;

    // ---------------------------------------------------------------------
    // Valid bits and load enables
    // ---------------------------------------------------------------------
    logic              p_v_reg;
    logic [NW:0]       dv_v_reg;
    logic              o_v_reg;
    logic              rdy_p;
    logic [NW:0]       rdy_dv;
    logic              rdy_o;

    always_comb
    begin
        rdy_o = !o_v_reg || rsp_ready;
        rdy_dv[NW] = !dv_v_reg[NW] || rdy_o;
        for (int k = NW - 1; k >= 0; k--)
        begin
            rdy_dv[k] = !dv_v_reg[k] || rdy_dv[k+1];
        end
        rdy_p = !p_v_reg || rdy_dv[0];
    end

    assign req_ready = rdy_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg  <= 1'b0;
            dv_v_reg <= '0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_p)
            begin
                p_v_reg <= req_valid;
            end
            if (rdy_dv[0])
            begin
                dv_v_reg[0] <= p_v_reg;
            end
            for (int k = 1; k <= NW; k++)
            begin
                if (rdy_dv[k])
                begin
                    dv_v_reg[k] <= dv_v_reg[k-1];
                end
            end
            if (rdy_o)
            begin
                o_v_reg <= dv_v_reg[NW];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: all products, and the averages
    // ---------------------------------------------------------------------
    prod_t             p_next;
    prod_t             p_reg;
    logic signed [W:0] sum_re;
    logic signed [W:0] sum_im;
    logic signed [W:0] adj_re;
    logic signed [W:0] adj_im;

    always_comb
    begin
        p_next.fn    = cia_pkg::func_t'(func);
        p_next.ar    = a_re;
        p_next.ai    = a_im;
        p_next.br    = b_re;
        p_next.bi    = b_im;
        p_next.arbr  = NW'(a_re) * NW'(b_re);
        p_next.aibi  = NW'(a_im) * NW'(b_im);
        p_next.aibr  = NW'(a_im) * NW'(b_re);
        p_next.arbi  = NW'(a_re) * NW'(b_im);
        p_next.sq_ar = NW'(a_re) * NW'(a_re);
        p_next.sq_ai = NW'(a_im) * NW'(a_im);
        p_next.sq_br = NW'(b_re) * NW'(b_re);
        p_next.sq_bi = NW'(b_im) * NW'(b_im);
        // halve toward zero: bump odd negative sums before the shift
        sum_re = (W+1)'(a_re) + (W+1)'(b_re);
        sum_im = (W+1)'(a_im) + (W+1)'(b_im);
        adj_re = sum_re + $signed({{W{1'b0}}, sum_re[W] & sum_re[0]});
        adj_im = sum_im + $signed({{W{1'b0}}, sum_im[W] & sum_im[0]});
        p_next.avg_re = adj_re >>> 1;
        p_next.avg_im = adj_im >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_p)
        begin
            p_reg <= p_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: sums of products, magnitudes, selection
    // ---------------------------------------------------------------------
    div_t               d0_next;
    logic signed [XW-1:0] nre;
    logic signed [XW-1:0] nim;
    logic signed [XW-1:0] mre;
    logic signed [XW-1:0] mim;
    logic [NW-1:0]      mag_a;
    logic [NW-1:0]      mag_b;

    always_comb
    begin
        nre   = XW'(p_reg.arbr) + XW'(p_reg.aibi);
        nim   = XW'(p_reg.aibr) - XW'(p_reg.arbi);
        mre   = nre[XW-1] ? -nre : nre;
        mim   = nim[XW-1] ? -nim : nim;
        mag_a = p_reg.sq_ar[NW-1:0] + p_reg.sq_ai[NW-1:0];
        mag_b = p_reg.sq_br[NW-1:0] + p_reg.sq_bi[NW-1:0];

        d0_next.fn     = p_reg.fn;
        d0_next.neg_re = nre[XW-1];
        d0_next.neg_im = nim[XW-1];
        d0_next.d      = mag_b;
        d0_next.rem_re = '0;
        d0_next.rem_im = '0;
        d0_next.num_re = mre[NW-1:0];
        d0_next.num_im = mim[NW-1:0];

        case (p_reg.fn)
            cia_pkg::FUNC_MUL:
            begin
                d0_next.val_re = XW'(p_reg.arbr) - XW'(p_reg.aibi);
                d0_next.val_im = XW'(p_reg.arbi) + XW'(p_reg.aibr);
            end
            cia_pkg::FUNC_MAX:
            begin
                if (mag_a >= mag_b)
                begin
                    d0_next.val_re = XW'(p_reg.ar);
                    d0_next.val_im = XW'(p_reg.ai);
                end
                else
                begin
                    d0_next.val_re = XW'(p_reg.br);
                    d0_next.val_im = XW'(p_reg.bi);
                end
            end
            cia_pkg::FUNC_AVG:
            begin
                d0_next.val_re = XW'(p_reg.avg_re);
                d0_next.val_im = XW'(p_reg.avg_im);
            end
            default:
            begin
                d0_next.val_re = '0;
                d0_next.val_im = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Divider: one restoring step per stage, both parts side by side
    // ---------------------------------------------------------------------
    div_t dv_reg [0:NW];
    div_t dv_next [1:NW];

    always_comb
    begin
        logic [NW:0] t_re;
        logic [NW:0] t_im;
        logic        q_re;
        logic        q_im;
        for (int k = 1; k <= NW; k++)
        begin
            dv_next[k] = dv_reg[k-1];
            t_re = {dv_reg[k-1].rem_re, dv_reg[k-1].num_re[NW-1]};
            t_im = {dv_reg[k-1].rem_im, dv_reg[k-1].num_im[NW-1]};
            q_re = t_re >= {1'b0, dv_reg[k-1].d};
            q_im = t_im >= {1'b0, dv_reg[k-1].d};
            dv_next[k].rem_re = q_re ? NW'(t_re - {1'b0, dv_reg[k-1].d}) : t_re[NW-1:0];
            dv_next[k].rem_im = q_im ? NW'(t_im - {1'b0, dv_reg[k-1].d}) : t_im[NW-1:0];
            dv_next[k].num_re = {dv_reg[k-1].num_re[NW-2:0], q_re};
            dv_next[k].num_im = {dv_reg[k-1].num_im[NW-2:0], q_im};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_dv[0])
        begin
            dv_reg[0] <= d0_next;
        end
        for (int k = 1; k <= NW; k++)
        begin
            if (rdy_dv[k])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: apply quotient sign, zero on a zero divisor
    // ---------------------------------------------------------------------
    logic signed [cia_pkg::RES_W-1:0] o_re_reg;
    logic signed [cia_pkg::RES_W-1:0] o_im_reg;
    logic                             o_dz_reg;
    logic signed [XW-1:0]             q_re_x;
    logic signed [XW-1:0]             q_im_x;
    logic signed [XW-1:0]             f_re;
    logic signed [XW-1:0]             f_im;
    logic                             f_dz;

    always_comb
    begin
        q_re_x = $signed({2'b00, dv_reg[NW].num_re});
        q_im_x = $signed({2'b00, dv_reg[NW].num_im});
        f_dz   = 1'b0;
        f_re   = dv_reg[NW].val_re;
        f_im   = dv_reg[NW].val_im;
        if (dv_reg[NW].fn == cia_pkg::FUNC_DIV)
        begin
            if (dv_reg[NW].d == '0)
            begin
                f_dz = 1'b1;
                f_re = '0;
                f_im = '0;
            end
            else
            begin
                f_re = dv_reg[NW].neg_re ? -q_re_x : q_re_x;
                f_im = dv_reg[NW].neg_im ? -q_im_x : q_im_x;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o)
        begin
            o_re_reg <= cia_pkg::RES_W'(f_re);
            o_im_reg <= cia_pkg::RES_W'(f_im);
            o_dz_reg <= f_dz;
        end
    end

    assign rsp_valid   = o_v_reg;
    assign res_re      = o_re_reg;
    assign res_im      = o_im_reg;
    assign div_by_zero = o_dz_reg;

`ifndef SYNTHESIS
    // a flagged response carries a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && div_by_zero |-> res_re == '0 && res_im == '0)
        else $error("div_by_zero with non-zero result");

    // an empty output register means the whole pipe can take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty output");

    // final divider remainders stay below a non-zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[NW] && dv_reg[NW].d != '0 |->
            dv_reg[NW].rem_re < dv_reg[NW].d && dv_reg[NW].rem_im < dv_reg[NW].d)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
